>>> hdl/rlp_pkg.sv
// Shared types, widths and constants for the radial lens predistortion block.
// Used by rlp_radius, rlp_poly, rlp_project and the top level; depends on nothing.
package rlp_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 18;
    localparam int COEF_W    = 32;
    localparam int ZOOM_W    = 18;
    localparam int NUM_COEF  = 7;
    localparam int Q30_W     = 30;
    localparam int ROOT_W    = 31;
    localparam int RAD_W     = 62;
    localparam int SCALE_W   = 38;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 40;

    localparam logic [Q30_W-1:0] Q30_MAX = '1;

    // floor(x/5) = (x * DIV5_MUL) >> DIV5_SHIFT for any 32 bit x
    localparam logic [31:0] DIV5_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ZOOM = 4'd7;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t coef_array_t [NUM_COEF];

    localparam coef_array_t COEF_RESET = '{
        32'sd336468, 32'sd49395560, 32'sd47302488, -32'sd6579313,
        -32'sd435976762, 32'sd964293978, -32'sd577603308
    };
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 18'd65536;

    // width of a signed offset from the center: holds both 0..65535 and 2^(F-1)
    function automatic int d_width(input int frac_bits);
        return ((frac_bits > IN_W) ? frac_bits : IN_W) + 1;
    endfunction

endpackage

>>> hdl/radial_lens_predistortion.sv
// Radial lens predistortion, top level: stream ports, configuration registers
// and the radius, polynomial and projection pipelines. Depends on rlp_pkg.
//
// Usage: a request on s_ carries one screen coordinate (u,v), unsigned with
// COORD_FRAC_BITS fraction bits. The m_ channel returns the predistorted
// coordinate as signed Q1.16 style values, saturated to 18 bits, one result
// for each request, in order.
// An accepted request reaches m_tvalid through 35 stages for offsets,
// squares and the 31-stage bit-serial root, 9 for the seven-term
// polynomial (one power of the radius per stage) and 5 for the projection.
// Throughput is one request per cycle unless a finished result is held;
// every stage is a register. All stages share one enable: when m_tvalid is
// high and m_tready low the whole pipeline holds and s_tready drops, nothing is lost or repeated.
// The cfg_ channel writes coefficients (index 0..6) and zoom (index 7);
// other indexes are dropped. cfg_ready is always high. Write only when no
// request is in flight.
// Synchronous reset (aresetn low) clears all valid bits and loads the
// default coefficients and unit zoom.
module radial_lens_predistortion #(
    parameter int COORD_FRAC_BITS = rlp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rlp_pkg::TDATA_IN_W-1:0]    s_tdata,   // u_in[15:0], v_in[31:16]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rlp_pkg::TDATA_OUT_W-1:0]   m_tdata,   // u_out[17:0], v_out[35:18], zero
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlp_pkg::CFG_DAT_W-1:0]     cfg_data
);
    localparam int F    = COORD_FRAC_BITS;
    localparam int D_W  = rlp_pkg::d_width(F);
    localparam int DP_W = 2 * D_W;
    localparam int OW   = rlp_pkg::OUT_W;
    localparam logic signed [OW-1:0] CENTER_OUT =
        (F - 1 >= OW - 1) ? rlp_pkg::OUT_MAX : OW'(1) << (F - 1);

    rlp_pkg::coef_array_t           coef_reg;
    logic [rlp_pkg::ZOOM_W-1:0]     zoom_reg;
    logic                           ce;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= rlp_pkg::COEF_RESET;
            zoom_reg <= rlp_pkg::ZOOM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < rlp_pkg::NUM_COEF; i++) begin
                if (cfg_index == rlp_pkg::CFG_IDX_W'(i)) begin
                    coef_reg[i] <= $signed(cfg_data);
                end
            end
            if (cfg_index == rlp_pkg::CFG_IDX_ZOOM) begin
                zoom_reg <= cfg_data[rlp_pkg::ZOOM_W-1:0];
            end
        end
    end

    // advance everything unless a finished result is held
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic                            rad_valid, poly_valid;
    logic [DP_W-1:0]                 rad_dp, poly_dp;
    logic [rlp_pkg::Q30_W-1:0]       rad_rn;
    logic signed [rlp_pkg::SCALE_W-1:0] poly_scale;
    logic signed [OW-1:0]            u_res, v_res;

    rlp_radius #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_radius (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .u_in      (s_tdata[15:0]),
        .v_in      (s_tdata[31:16]),
        .out_valid (rad_valid),
        .dp_out    (rad_dp),
        .rn_out    (rad_rn)
    );

    rlp_poly #(.DP_W(DP_W)) u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (rad_valid),
        .dp_in     (rad_dp),
        .rn_in     (rad_rn),
        .coef      (coef_reg),
        .out_valid (poly_valid),
        .dp_out    (poly_dp),
        .scale_out (poly_scale)
    );

    rlp_project #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (poly_valid),
        .dp_in     (poly_dp),
        .scale_in  (poly_scale),
        .zoom      (zoom_reg),
        .out_valid (m_tvalid),
        .u_out     (u_res),
        .v_out     (v_res)
    );

    assign m_tdata = {4'b0000, v_res, u_res};

    a_stall_only_on_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    a_zero_zoom_gives_center: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && zoom_reg == '0) |->
        ($signed(m_tdata[17:0]) == CENTER_OUT && $signed(m_tdata[35:18]) == CENTER_OUT))
        else $error("zero zoom did not return the center");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

>>> hdl/rlp_radius.sv
// Front end: center offsets, axis scaling, sum of squares and a one-bit-per-stage
// square root pipeline. Depends on rlp_pkg.
module rlp_radius #(
    parameter int COORD_FRAC_BITS = rlp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              ce,
    input  logic                                              in_valid,
    input  logic [rlp_pkg::IN_W-1:0]                          u_in,
    input  logic [rlp_pkg::IN_W-1:0]                          v_in,
    output logic                                              out_valid,
    output logic [2*rlp_pkg::d_width(COORD_FRAC_BITS)-1:0]    dp_out,
    output logic [rlp_pkg::Q30_W-1:0]                         rn_out
);
    localparam int F     = COORD_FRAC_BITS;
    localparam int D_W   = rlp_pkg::d_width(F);
    localparam int AV_W  = D_W - 1;
    localparam int XW    = AV_W + 31 - F;
    localparam int Q_W   = rlp_pkg::Q30_W;
    localparam int R_W   = rlp_pkg::ROOT_W;
    localparam int RAD_W = rlp_pkg::RAD_W;
    localparam logic [D_W-1:0] CENTER = D_W'(1) << (F - 1);

    // stage 1: offsets and axis scaling
    logic signed [D_W-1:0] du_c, dv_c, du_neg, dv_neg;
    logic [AV_W-1:0] au_c, av_c;
    logic [XW-1:0]   xw_c, ys_c;

    always_comb begin
        du_c   = $signed(D_W'(u_in)) - $signed(CENTER);
        dv_c   = $signed(D_W'(v_in)) - $signed(CENTER);
        du_neg = -du_c;
        dv_neg = -dv_c;
        au_c   = du_c[D_W-1] ? du_neg[AV_W-1:0] : du_c[AV_W-1:0];
        av_c   = dv_c[D_W-1] ? dv_neg[AV_W-1:0] : dv_c[AV_W-1:0];
        xw_c   = (XW'(au_c) * XW'(9)) << (27 - F);
        ys_c   = XW'(av_c) << (30 - F);
    end

    logic signed [D_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg, du3_reg, dv3_reg;
    logic [Q_W-1:0]        xn1_reg, xn2_reg, yn2_reg;
    logic                  yovf1_reg;
    logic [25:0]           ya1_reg;
    logic [59:0]           xx3_reg, yy3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            du1_reg   <= du_c;
            dv1_reg   <= dv_c;
            xn1_reg   <= (xw_c > XW'(rlp_pkg::Q30_MAX)) ? rlp_pkg::Q30_MAX : xw_c[Q_W-1:0];
            yovf1_reg <= |ys_c[XW-1:Q_W];
            ya1_reg   <= ys_c[29:4];
        end
    end

    // stage 2: y = round(|dv| * 81/80) as 16a + floor((a+2)/5)
    logic [26:0] a27_c;
    logic [58:0] dprod_c;
    logic [30:0] yfull_c;

    always_comb begin
        a27_c   = {1'b0, ya1_reg} + 27'd2;
        dprod_c = 59'(a27_c) * 59'(rlp_pkg::DIV5_MUL);
        yfull_c = {1'b0, ya1_reg, 4'b0000} + 31'(dprod_c[58:rlp_pkg::DIV5_SHIFT]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            du2_reg <= du1_reg;
            dv2_reg <= dv1_reg;
            xn2_reg <= xn1_reg;
            yn2_reg <= (yovf1_reg || yfull_c > 31'(rlp_pkg::Q30_MAX)) ?
                       rlp_pkg::Q30_MAX : yfull_c[Q_W-1:0];
        end
    end

    // stage 3: squares
    always_ff @(posedge aclk) begin
        if (ce) begin
            du3_reg <= du2_reg;
            dv3_reg <= dv2_reg;
            xx3_reg <= 60'(xn2_reg) * 60'(xn2_reg);
            yy3_reg <= 60'(yn2_reg) * 60'(yn2_reg);
        end
    end

    // stage 4 loads the sum into the root pipeline at index 0
    logic [RAD_W-1:0]   rem_reg  [0:R_W];
    logic [R_W-1:0]     root_reg [0:R_W];
    logic [2*D_W-1:0]   dp_reg   [0:R_W];
    logic [R_W+3:0]     vld_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= RAD_W'(xx3_reg) + RAD_W'(yy3_reg);
            root_reg[0] <= '0;
            dp_reg[0]   <= {dv3_reg, du3_reg};
        end
    end

    for (genvar i = 0; i < R_W; i++) begin : g_sqrt
        localparam int B = R_W - 1 - i;
        logic [RAD_W-1:0] trial;
        logic             fits;

        always_comb begin
            trial = (RAD_W'(root_reg[i]) << (B + 1)) | (RAD_W'(1) << (2 * B));
            fits  = rem_reg[i] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i+1]  <= fits ? rem_reg[i] - trial : rem_reg[i];
                root_reg[i+1] <= fits ? (root_reg[i] | (R_W'(1) << B)) : root_reg[i];
                dp_reg[i+1]   <= dp_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[R_W+2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[R_W+3];
    assign dp_out    = dp_reg[R_W];
    assign rn_out    = (root_reg[R_W] > R_W'(rlp_pkg::Q30_MAX)) ?
                       rlp_pkg::Q30_MAX : root_reg[R_W][Q_W-1:0];

endmodule

>>> hdl/rlp_poly.sv
// Distortion polynomial: powers of the radius, one per stage, with the
// coefficient products accumulated behind them into the radial scale. Depends on rlp_pkg.
module rlp_poly #(
    parameter int DP_W = 2 * rlp_pkg::d_width(rlp_pkg::COORD_FRAC_BITS_DEF)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 ce,
    input  logic                                 in_valid,
    input  logic [DP_W-1:0]                      dp_in,
    input  logic [rlp_pkg::Q30_W-1:0]            rn_in,
    input  rlp_pkg::coef_array_t                 coef,
    output logic                                 out_valid,
    output logic [DP_W-1:0]                      dp_out,
    output logic signed [rlp_pkg::SCALE_W-1:0]   scale_out
);
    localparam int N      = rlp_pkg::NUM_COEF;
    localparam int Q_W    = rlp_pkg::Q30_W;
    localparam int TERM_W = 36;
    localparam int ACC_W  = rlp_pkg::SCALE_W;

    logic [Q_W-1:0]           pw_reg   [0:N];
    logic [Q_W-1:0]           rn_reg   [0:N];
    logic signed [ACC_W-1:0]  acc_reg  [0:N];
    logic signed [TERM_W-1:0] term_reg [0:N];
    logic [DP_W-1:0]          dp_reg   [0:N];
    logic [N+1:0]             vld_reg;
    logic signed [ACC_W-1:0]  scale_reg;
    logic [DP_W-1:0]          dpo_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            pw_reg[0]   <= rn_in;
            rn_reg[0]   <= rn_in;
            acc_reg[0]  <= '0;
            term_reg[0] <= '0;
            dp_reg[0]   <= dp_in;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_term
        logic signed [62:0] cprod;
        logic [59:0]        pprod;
        logic [60:0]        pround;

        always_comb begin
            cprod  = coef[k] * $signed({1'b0, pw_reg[k]});
            pprod  = 60'(pw_reg[k]) * 60'(rn_reg[k]);
            pround = 61'(pprod) + (61'(1) << (Q_W - 1));
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                pw_reg[k+1]   <= pround[59:30];
                rn_reg[k+1]   <= rn_reg[k];
                term_reg[k+1] <= cprod[62:27];
                acc_reg[k+1]  <= acc_reg[k] + ACC_W'(term_reg[k]);
                dp_reg[k+1]   <= dp_reg[k];
            end
        end
    end

    // add the last term and the unit offset
    always_ff @(posedge aclk) begin
        if (ce) begin
            scale_reg <= acc_reg[N] + ACC_W'(term_reg[N]) + (ACC_W'(1) <<< Q_W);
            dpo_reg   <= dp_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[N:0], in_valid};
        end
    end

    assign out_valid = vld_reg[N+1];
    assign dp_out    = dpo_reg;
    assign scale_out = scale_reg;

endmodule

>>> hdl/rlp_project.sv
// Projection: offset times radial scale, times zoom, recentered and saturated,
// one lane per axis with the wide products split in two. Depends on rlp_pkg.
module rlp_project #(
    parameter int COORD_FRAC_BITS = rlp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             ce,
    input  logic                                             in_valid,
    input  logic [2*rlp_pkg::d_width(COORD_FRAC_BITS)-1:0]   dp_in,
    input  logic signed [rlp_pkg::SCALE_W-1:0]               scale_in,
    input  logic [rlp_pkg::ZOOM_W-1:0]                       zoom,
    output logic                                             out_valid,
    output logic signed [rlp_pkg::OUT_W-1:0]                 u_out,
    output logic signed [rlp_pkg::OUT_W-1:0]                 v_out
);
    localparam int F    = COORD_FRAC_BITS;
    localparam int D_W  = rlp_pkg::d_width(F);
    localparam int S_W  = rlp_pkg::SCALE_W;
    localparam int PW   = D_W + S_W + 1;
    localparam int M_W  = PW - 18;
    localparam int ZW   = M_W + rlp_pkg::ZOOM_W + 2;
    localparam int ZO_W = ZW - 28;
    localparam int OW   = ZO_W + 1;
    localparam logic [OW-1:0] CENTER = OW'(1) << (F - 1);

    logic signed [rlp_pkg::OUT_W-1:0] res [2];
    logic [4:0] vld_reg;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [D_W-1:0]      d;
        logic signed [D_W+18:0]     phi_reg;
        logic signed [D_W+19:0]     plo_reg;
        logic signed [PW-1:0]       psum;
        logic signed [M_W-1:0]      m_reg;
        logic signed [D_W+17:0]     zhi_reg;
        logic signed [42:0]         zlo_reg;
        logic signed [ZW-1:0]       zsum;
        logic signed [ZO_W-1:0]     z_reg;
        logic signed [OW-1:0]       o;
        logic signed [rlp_pkg::OUT_W-1:0] o_reg;

        assign d = dp_in[l*D_W +: D_W];

        always_comb begin
            psum = (PW'(phi_reg) <<< 19) + PW'(plo_reg) + (PW'(1) <<< 17);
            zsum = (ZW'(zhi_reg) <<< 23) + ZW'(zlo_reg) + (ZW'(1) <<< 27);
            o    = OW'(z_reg) + $signed(CENTER);
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                phi_reg <= d * $signed(scale_in[S_W-1:19]);
                plo_reg <= d * $signed({1'b0, scale_in[18:0]});
                m_reg   <= psum[PW-1:18];
                zhi_reg <= $signed(m_reg[M_W-1:23]) * $signed({1'b0, zoom});
                zlo_reg <= $signed({1'b0, m_reg[22:0]}) * $signed({1'b0, zoom});
                z_reg   <= zsum[ZW-1:28];
                if (o > OW'(rlp_pkg::OUT_MAX)) begin
                    o_reg <= rlp_pkg::OUT_MAX;
                end else if (o < OW'(rlp_pkg::OUT_MIN)) begin
                    o_reg <= rlp_pkg::OUT_MIN;
                end else begin
                    o_reg <= o[rlp_pkg::OUT_W-1:0];
                end
            end
        end

        assign res[l] = o_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign out_valid = vld_reg[4];
    assign u_out     = res[0];
    assign v_out     = res[1];

endmodule

>>> bench/tb_top.sv
// Testbench for radial_lens_predistortion: drives coordinate requests, predicts each
// distorted coordinate from the polynomial lens model and checks results in order.
// Depends on rlp_pkg and the radial_lens_predistortion top level.
module tb_top;

    localparam int FB = rlp_pkg::COORD_FRAC_BITS_DEF;
    localparam int LATENCY = 49;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [rlp_pkg::CFG_IDX_W-1:0] IDX_COEF_R1 = '0;

    typedef struct packed {
        logic signed [rlp_pkg::OUT_W-1:0] v;
        logic signed [rlp_pkg::OUT_W-1:0] u;
    } warp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rlp_pkg::TDATA_IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rlp_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rlp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rlp_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    radial_lens_predistortion DUT (.*);

    always #1 aclk = ~aclk;

    longint lens_coef [rlp_pkg::NUM_COEF];
    longint lens_zoom;
    warp_t warp_fifo [$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    function automatic longint fshift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint rshift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint isqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [rlp_pkg::OUT_W-1:0] project(longint d, longint scale);
        longint m, z;
        m = rshift(d * scale, 18);
        z = rshift(m * lens_zoom, 28) + (longint'(1) << (FB - 1));
        if (z > 131071) z = 131071;
        if (z < -131072) z = -131072;
        return z[rlp_pkg::OUT_W-1:0];
    endfunction

    function automatic warp_t predict_warp(logic [15:0] ui, logic [15:0] vi);
        longint du, dv, au, av, xn, yn, rn, pw, usum;
        warp_t w;
        du = longint'(ui) - (longint'(1) << (FB - 1));
        dv = longint'(vi) - (longint'(1) << (FB - 1));
        au = du < 0 ? -du : du;
        av = dv < 0 ? -dv : dv;
        xn = (au * 9) << (27 - FB);
        yn = (((av * 81) << (30 - FB)) + 40) / 80;
        if (xn > 64'h3FFFFFFF) xn = 64'h3FFFFFFF;
        if (yn > 64'h3FFFFFFF) yn = 64'h3FFFFFFF;
        rn = isqrt(xn * xn + yn * yn);
        if (rn > 64'h3FFFFFFF) rn = 64'h3FFFFFFF;
        pw = rn;
        usum = 0;
        for (int k = 0; k < rlp_pkg::NUM_COEF; k++) begin
            if (k > 0) pw = (pw * rn + (longint'(1) << 29)) >> 30;
            usum += fshift(lens_coef[k] * pw, 27);
        end
        w.u = project(du, (longint'(1) << 30) + usum);
        w.v = project(dv, (longint'(1) << 30) + usum);
        return w;
    endfunction

    // leaves s_tvalid high after the accept; the next request or drain decides
    task automatic send_coord(logic [15:0] ui, logic [15:0] vi);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {vi, ui};
        warp_fifo.push_back(predict_warp(ui, vi));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop the request line, wait until every result is back, then let it drain fully
    task automatic drain;
        s_tvalid <= 1'b0;
        while (warp_fifo.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_reg(logic [rlp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx < rlp_pkg::NUM_COEF) lens_coef[idx] = longint'(signed'(val));
        else if (idx == rlp_pkg::CFG_IDX_ZOOM) lens_zoom = val[rlp_pkg::ZOOM_W-1:0];
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(stall_pct > 0 && $urandom_range(99, 0) < stall_pct);
            if (m_tvalid && m_tready) begin
                warp_t got, want;
                got = m_tdata[2*rlp_pkg::OUT_W-1:0];
                if (warp_fifo.size() == 0) begin
                    $display("%0t: unexpected result u=%0d v=%0d", $time, got.u, got.v);
                    errors++;
                end else begin
                    want = warp_fifo.pop_front();
                    if (got.u !== want.u) begin
                        $display("%0t: u_out expected %0d actual %0d", $time, want.u, got.u);
                        errors++;
                    end
                    if (got.v !== want.v) begin
                        $display("%0t: v_out expected %0d actual %0d", $time, want.v, got.v);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed;
        logic [15:0] edge_vals [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001, 16'h4000};
        foreach (edge_vals[i]) begin
            send_coord(edge_vals[i], edge_vals[5 - i]);
            send_coord(edge_vals[i], edge_vals[i]);
        end
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_coord(16'($urandom), 16'($urandom));
        drain();
    endtask

    task automatic test_config_extremes;
        // negative scale: large negative linear term, and saturation with max zoom
        write_reg(IDX_COEF_R1, 32'h8000_0000);
        write_reg(rlp_pkg::CFG_IDX_ZOOM, 32'h3FFFF);
        test_random(60);
        for (int k = 0; k < rlp_pkg::NUM_COEF; k++)
            write_reg(IDX_COEF_R1 + rlp_pkg::CFG_IDX_W'(k), 32'h7FFF_FFFF);
        write_reg(rlp_pkg::CFG_IDX_ZOOM, 32'h0);
        test_random(40);
        write_reg(rlp_pkg::CFG_IDX_ZOOM, 32'h3FFFF);
        send_coord(16'h0000, 16'hFFFF);
        send_coord(16'hFFFF, 16'h0000);
        test_random(60);
        // index beyond seven is dropped
        write_reg(4'd9, 32'h1234_5678);
        write_reg(4'd15, 32'hFFFF_FFFF);
        for (int k = 0; k < rlp_pkg::NUM_COEF; k++)
            write_reg(IDX_COEF_R1 + rlp_pkg::CFG_IDX_W'(k), $urandom);
        write_reg(rlp_pkg::CFG_IDX_ZOOM, $urandom);
        test_random(100);
        for (int k = 0; k < rlp_pkg::NUM_COEF; k++)
            write_reg(IDX_COEF_R1 + rlp_pkg::CFG_IDX_W'(k), rlp_pkg::COEF_RESET[k]);
        write_reg(rlp_pkg::CFG_IDX_ZOOM, 32'(rlp_pkg::ZOOM_RESET));
    endtask

    initial begin
        for (int k = 0; k < rlp_pkg::NUM_COEF; k++) lens_coef[k] = rlp_pkg::COEF_RESET[k];
        lens_zoom = rlp_pkg::ZOOM_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        idle_pct = 0;  stall_pct = 0;  test_random(250);
        idle_pct = 70; stall_pct = 0;  test_random(250);
        idle_pct = 0;  stall_pct = 70; test_random(250);
        idle_pct = 29; stall_pct = 29; test_random(250);
        stall_pct = 0;
        drain();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
